// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- design/pdpc_pkg.sv -----
`default_nettype none
package pdpc_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int PI_Q       = 12868;
   localparam int TWO_PI_Q   = 25736;
   localparam int RATE_SCALE = 1000000;
   localparam int LIN_SHIFT  = 12;

   localparam int ROOT_STEPS = 33;
   localparam int DIV_STEPS  = 54;
   localparam int CNT_W      = 6;

   localparam logic [43:0] Q_CLAMP = 44'h800_0000_0000;
   localparam logic [63:0] D_CLAMP = 64'h1000_0000_0000_0000;

   localparam logic [19:0] LIN_KP_RST = 20'd10568;
   localparam logic [19:0] LIN_KD_RST = 20'd193;
   localparam logic [19:0] ROT_KP_RST = 20'd8192;
   localparam logic [19:0] ROT_KD_RST = 20'd410;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TARGET_DISTANCE = 3'd0,
      REG_TARGET_ANGLE    = 3'd1,
      REG_TOL_DISTANCE    = 3'd2,
      REG_TOL_ANGLE       = 3'd3,
      REG_LIN_KP          = 3'd4,
      REG_LIN_KD          = 3'd5,
      REG_ROT_KP          = 3'd6,
      REG_ROT_KD          = 3'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_DIFF,
      OP_SQUARE,
      OP_SUM,
      OP_ROOT,
      OP_PREP,
      OP_MUL,
      OP_DIV,
      OP_CLAMP,
      OP_DMUL,
      OP_DSUM,
      OP_FIN,
      OP_PUSH
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_CLAMP,
      ST_DMUL,
      ST_DSUM,
      ST_FIN,
      ST_PUSH
   } state_type;

   typedef struct packed {
      op_type op;
      logic   lane;
   } cmd_type;

   typedef struct packed {
      logic dt_zero;
   } status_type;

endpackage
`default_nettype wire

// ----- design/pdpc_req_if.sv -----
`default_nettype none
interface pdpc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [14:0] heading;
   logic        [31:0] stamp_us;

   modport source (output valid, pos_x, pos_y, heading, stamp_us, input ready);
   modport sink (input valid, pos_x, pos_y, heading, stamp_us, output ready);
endinterface
`default_nettype wire

// ----- design/pdpc_rsp_if.sv -----
`default_nettype none
interface pdpc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] speed_cmd;
   logic signed [31:0] turn_cmd;
   logic               arrived;

   modport source (output valid, speed_cmd, turn_cmd, arrived, input ready);
   modport sink (input valid, speed_cmd, turn_cmd, arrived, output ready);
endinterface
`default_nettype wire

// ----- design/pdpc_ctrl.sv -----
`default_nettype none
`include "assert_macros.svh"
module pdpc_ctrl
   import pdpc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output cmd_type         cmd,
   input  wire status_type status
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              lane_ff, lane_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         lane_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         lane_ff      <= lane_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      lane_in      = lane_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = OP_NONE;
      cmd.lane     = lane_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_CAPTURE;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.op   = OP_SQUARE;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.op   = OP_SUM;
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.op = OP_ROOT;
            if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_PREP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_PREP: begin
            cmd.op   = OP_PREP;
            lane_in  = 1'b0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op   = OP_MUL;
            cnt_in   = '0;
            state_in = status.dt_zero ? ST_CLAMP : ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DIV;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_CLAMP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_CLAMP: begin
            cmd.op   = OP_CLAMP;
            state_in = ST_DMUL;
         end
         ST_DMUL: begin
            cmd.op   = OP_DMUL;
            state_in = ST_DSUM;
         end
         ST_DSUM: begin
            cmd.op   = OP_DSUM;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.op = OP_FIN;
            if (!lane_ff) begin
               lane_in  = 1'b1;
               state_in = ST_MUL;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_PUSH;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPLY(a_push_has_slot, clock, reset, cmd.op == OP_PUSH, !rsp_valid_ff || rsp_ready)
   `ASSERT_IMPLY(a_div_count, clock, reset, state_ff == ST_DIV, cnt_ff < CNT_W'(DIV_STEPS))

endmodule
`default_nettype wire

// ----- design/pdpc_datapath.sv -----
`default_nettype none
module pdpc_datapath
   import pdpc_pkg::*;
#(
   parameter int POS_FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic signed [31:0]    pos_x,
   input  wire logic signed [31:0]    pos_y,
   input  wire logic signed [14:0]    heading,
   input  wire logic        [31:0]    stamp_us,
   input  wire cmd_type               cmd,
   output status_type                 status,
   output logic signed [31:0]         speed_cmd,
   output logic signed [31:0]         turn_cmd,
   output logic                       arrived
);

   localparam int ANG_SHIFT = 24 - POS_FRAC_BITS;
   localparam logic signed [62:0] SAT_MAX = 63'sd2147483647;
   localparam logic signed [62:0] SAT_MIN = -63'sd2147483648;

   function automatic logic [19:0] abs20(input logic signed [19:0] v);
      abs20 = v[19] ? 20'(-v) : 20'(v);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [62:0] v);
      if (v > SAT_MAX) begin
         sat32 = 32'sh7fff_ffff;
      end else if (v < SAT_MIN) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   // configuration
   logic signed [31:0] target_dist_ff, target_dist_in;
   logic signed [15:0] target_ang_ff, target_ang_in;
   logic        [30:0] dist_tol_ff, dist_tol_in;
   logic        [14:0] tol_ang_ff, tol_ang_in;
   logic        [19:0] lin_kp_ff, lin_kp_in, lin_kd_ff, lin_kd_in;
   logic        [19:0] rot_kp_ff, rot_kp_in, rot_kd_ff, rot_kd_in;

   // pose history
   logic               started_ff, started_in;
   logic signed [31:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic signed [16:0] start_h_ff, start_h_in, prev_h_ff, prev_h_in;
   logic        [31:0] prev_stamp_ff, prev_stamp_in;
   logic        [32:0] prev_dist_ff, prev_dist_in;

   // working registers
   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic signed [16:0] h_ff, h_in;
   logic        [31:0] stamp_ff, stamp_in;
   logic        [31:0] ux_ff, ux_in, uy_ff, uy_in;
   logic        [63:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic        [65:0] rad_ff, rad_in;
   logic        [34:0] srem_ff, srem_in;
   logic        [32:0] root_ff, root_in;
   logic signed [34:0] lin_err_ff, lin_err_in, lin_diff_ff, lin_diff_in;
   logic signed [19:0] ang_err_ff, ang_err_in, ang_diff_ff, ang_diff_in;
   logic               lin_en_ff, lin_en_in, arr_ff, arr_in;
   logic        [31:0] dt_ff, dt_in;
   logic signed [55:0] p_ff, p_in;
   logic               num_neg_ff, num_neg_in;
   logic        [53:0] quo_ff, quo_in;
   logic        [31:0] drem_ff, drem_in;
   logic        [43:0] qm_ff, qm_in;
   logic        [51:0] dlo_ff, dlo_in;
   logic        [31:0] dhi_ff, dhi_in;
   logic signed [61:0] d_ff, d_in;
   logic signed [31:0] speed_res_ff, speed_res_in, turn_res_ff, turn_res_in;
   logic signed [31:0] speed_out_ff, speed_out_in, turn_out_ff, turn_out_in;
   logic               arr_out_ff, arr_out_in;

   // combinational terms
   logic signed [32:0] dx, dy, dx_neg, dy_neg;
   logic        [63:0] sqx_prod, sqy_prod;
   logic        [64:0] sq_sum;
   logic        [36:0] rem_sh, trial;
   logic               neg;
   logic signed [33:0] root_s, cur0;
   logic signed [35:0] dist_err, dist_err_neg;
   logic               dist_ok, ang_ok;
   logic signed [19:0] h20, ta20, hs_old20, hp20, hs20, dh20, hu20, e20;
   logic signed [34:0] cur_mag, last_mag, cur_d, last_d, tgt35;
   logic signed [32:0] tgt33, tgt33_neg;
   logic        [31:0] hp_stamp;
   logic signed [34:0] err_sel, diff_sel;
   logic        [19:0] kp_sel, kd_sel;
   logic signed [20:0] kp_s, rate_s;
   logic signed [55:0] p_prod, num_prod, num_neg_v;
   logic        [32:0] drem_sh;
   logic        [63:0] dm;
   logic        [60:0] dmc;
   logic signed [61:0] dmag;
   logic signed [62:0] total, sh_lin, sh_ang;

   always_comb begin
      target_dist_in = target_dist_ff;
      target_ang_in  = target_ang_ff;
      dist_tol_in    = dist_tol_ff;
      tol_ang_in     = tol_ang_ff;
      lin_kp_in      = lin_kp_ff;
      lin_kd_in      = lin_kd_ff;
      rot_kp_in      = rot_kp_ff;
      rot_kd_in      = rot_kd_ff;
      if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_TARGET_DISTANCE: target_dist_in = csr_wdata;
            REG_TARGET_ANGLE:    target_ang_in  = csr_wdata[15:0];
            REG_TOL_DISTANCE:    dist_tol_in    = csr_wdata[30:0];
            REG_TOL_ANGLE:       tol_ang_in     = csr_wdata[14:0];
            REG_LIN_KP:          lin_kp_in      = csr_wdata[19:0];
            REG_LIN_KD:          lin_kd_in      = csr_wdata[19:0];
            REG_ROT_KP:          rot_kp_in      = csr_wdata[19:0];
            REG_ROT_KD:          rot_kd_in      = csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // distance from start
      dx       = {x_ff[31], x_ff} - {start_x_ff[31], start_x_ff};
      dy       = {y_ff[31], y_ff} - {start_y_ff[31], start_y_ff};
      dx_neg   = -dx;
      dy_neg   = -dy;
      sqx_prod = ux_ff * ux_ff;
      sqy_prod = uy_ff * uy_ff;
      sq_sum   = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      rem_sh   = {srem_ff, rad_ff[65:64]};
      trial    = {2'b00, root_ff, 2'b01};

      // arrival against the current start pose
      neg          = target_dist_ff[31];
      root_s       = {1'b0, root_ff};
      cur0         = neg ? -root_s : root_s;
      dist_err     = {{2{cur0[33]}}, cur0} - {{4{target_dist_ff[31]}}, target_dist_ff};
      dist_err_neg = -dist_err;
      dist_ok      = (dist_err[35] ? dist_err_neg : dist_err) <= $signed({5'd0, dist_tol_ff});
      h20      = {{3{h_ff[16]}}, h_ff};
      ta20     = {{4{target_ang_ff[15]}}, target_ang_ff};
      hs_old20 = {{3{start_h_ff[16]}}, start_h_ff};
      e20      = ta20 - (h20 - hs_old20);
      ang_ok   = (abs20(e20) <= {5'd0, tol_ang_ff}) ||
                 (abs20(e20 + 20'(TWO_PI_Q)) <= {5'd0, tol_ang_ff}) ||
                 (abs20(e20 - 20'(TWO_PI_Q)) <= {5'd0, tol_ang_ff});

      // loop errors, first sample takes itself as start and previous
      hp20 = started_ff ? {{3{prev_h_ff[16]}}, prev_h_ff} : h20;
      hs20 = started_ff ? hs_old20 : h20;
      dh20 = h20 - hp20;
      if (dh20 < -20'sd12868) begin
         hu20 = h20 + 20'(TWO_PI_Q);
      end else if (dh20 > 20'(PI_Q)) begin
         hu20 = h20 - 20'(TWO_PI_Q);
      end else begin
         hu20 = h20;
      end
      cur_mag   = started_ff ? {2'b00, root_ff} : '0;
      last_mag  = started_ff ? {2'b00, prev_dist_ff} : '0;
      cur_d     = neg ? -cur_mag : cur_mag;
      last_d    = neg ? -last_mag : last_mag;
      tgt35     = {{3{target_dist_ff[31]}}, target_dist_ff};
      tgt33     = {target_dist_ff[31], target_dist_ff};
      tgt33_neg = -tgt33;
      hp_stamp  = started_ff ? prev_stamp_ff : stamp_ff;

      // lane operands
      err_sel  = cmd.lane ? {{15{ang_err_ff[19]}}, ang_err_ff} : lin_err_ff;
      diff_sel = cmd.lane ? {{15{ang_diff_ff[19]}}, ang_diff_ff} : lin_diff_ff;
      kp_sel   = cmd.lane ? rot_kp_ff : lin_kp_ff;
      kd_sel   = cmd.lane ? rot_kd_ff : lin_kd_ff;
      kp_s     = {1'b0, kp_sel};
      rate_s   = 21'(RATE_SCALE);
      p_prod   = kp_s * err_sel;
      num_prod = diff_sel * rate_s;
      num_neg_v = -num_prod;
      drem_sh  = {drem_ff, quo_ff[53]};
      dm       = {12'd0, dlo_ff} + {dhi_ff, 32'd0};
      dmc      = (dm > D_CLAMP) ? D_CLAMP[60:0] : dm[60:0];
      dmag     = {1'b0, dmc};
      total    = {{7{p_ff[55]}}, p_ff} + {d_ff[61], d_ff};
      sh_lin   = total >>> LIN_SHIFT;
      sh_ang   = total >>> ANG_SHIFT;
   end

   always_comb begin
      started_in    = started_ff;
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      start_h_in    = start_h_ff;
      prev_h_in     = prev_h_ff;
      prev_stamp_in = prev_stamp_ff;
      prev_dist_in  = prev_dist_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      h_in          = h_ff;
      stamp_in      = stamp_ff;
      ux_in         = ux_ff;
      uy_in         = uy_ff;
      sqx_in        = sqx_ff;
      sqy_in        = sqy_ff;
      rad_in        = rad_ff;
      srem_in       = srem_ff;
      root_in       = root_ff;
      lin_err_in    = lin_err_ff;
      lin_diff_in   = lin_diff_ff;
      ang_err_in    = ang_err_ff;
      ang_diff_in   = ang_diff_ff;
      lin_en_in     = lin_en_ff;
      arr_in        = arr_ff;
      dt_in         = dt_ff;
      p_in          = p_ff;
      num_neg_in    = num_neg_ff;
      quo_in        = quo_ff;
      drem_in       = drem_ff;
      qm_in         = qm_ff;
      dlo_in        = dlo_ff;
      dhi_in        = dhi_ff;
      d_in          = d_ff;
      speed_res_in  = speed_res_ff;
      turn_res_in   = turn_res_ff;
      speed_out_in  = speed_out_ff;
      turn_out_in   = turn_out_ff;
      arr_out_in    = arr_out_ff;
      case (cmd.op)
         OP_CAPTURE: begin
            x_in     = pos_x;
            y_in     = pos_y;
            h_in     = {{2{heading[14]}}, heading};
            stamp_in = stamp_us;
         end
         OP_DIFF: begin
            ux_in = dx[32] ? dx_neg[31:0] : dx[31:0];
            uy_in = dy[32] ? dy_neg[31:0] : dy[31:0];
         end
         OP_SQUARE: begin
            sqx_in = sqx_prod;
            sqy_in = sqy_prod;
         end
         OP_SUM: begin
            rad_in  = {1'b0, sq_sum};
            srem_in = '0;
            root_in = '0;
         end
         OP_ROOT: begin
            rad_in = {rad_ff[63:0], 2'b00};
            if (rem_sh >= trial) begin
               srem_in = 35'(rem_sh - trial);
               root_in = {root_ff[31:0], 1'b1};
            end else begin
               srem_in = rem_sh[34:0];
               root_in = {root_ff[31:0], 1'b0};
            end
         end
         OP_PREP: begin
            arr_in      = dist_ok && ang_ok;
            lin_en_in   = (tgt33[32] ? tgt33_neg : tgt33) > $signed({2'b00, dist_tol_ff});
            lin_err_in  = tgt35 - cur_d;
            lin_diff_in = last_d - cur_d;
            ang_err_in  = ta20 - (hu20 - hs20);
            ang_diff_in = hp20 - hu20;
            dt_in       = stamp_ff - hp_stamp;
            started_in    = 1'b1;
            prev_h_in     = hu20[16:0];
            prev_stamp_in = stamp_ff;
            prev_dist_in  = cur_mag[32:0];
            if (!started_ff) begin
               start_x_in = x_ff;
               start_y_in = y_ff;
               start_h_in = h_ff;
            end
         end
         OP_MUL: begin
            p_in       = p_prod;
            num_neg_in = num_prod[55];
            quo_in     = num_prod[55] ? num_neg_v[53:0] : num_prod[53:0];
            drem_in    = '0;
         end
         OP_DIV: begin
            if (drem_sh >= {1'b0, dt_ff}) begin
               drem_in = 32'(drem_sh - {1'b0, dt_ff});
               quo_in  = {quo_ff[52:0], 1'b1};
            end else begin
               drem_in = drem_sh[31:0];
               quo_in  = {quo_ff[52:0], 1'b0};
            end
         end
         OP_CLAMP: begin
            if (dt_ff == '0) begin
               qm_in = '0;
            end else if (quo_ff > {10'd0, Q_CLAMP}) begin
               qm_in = Q_CLAMP;
            end else begin
               qm_in = quo_ff[43:0];
            end
         end
         OP_DMUL: begin
            dlo_in = qm_ff[31:0] * kd_sel;
            dhi_in = qm_ff[43:32] * kd_sel;
         end
         OP_DSUM: begin
            d_in = num_neg_ff ? -dmag : dmag;
         end
         OP_FIN: begin
            if (cmd.lane) begin
               turn_res_in = sat32(sh_ang);
            end else begin
               speed_res_in = lin_en_ff ? sat32(sh_lin) : '0;
            end
         end
         OP_PUSH: begin
            speed_out_in = speed_res_ff;
            turn_out_in  = turn_res_ff;
            arr_out_in   = arr_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_dist_ff <= '0;
         target_ang_ff  <= '0;
         dist_tol_ff    <= '0;
         tol_ang_ff     <= '0;
         lin_kp_ff      <= LIN_KP_RST;
         lin_kd_ff      <= LIN_KD_RST;
         rot_kp_ff      <= ROT_KP_RST;
         rot_kd_ff      <= ROT_KD_RST;
         started_ff     <= 1'b0;
         start_x_ff     <= '0;
         start_y_ff     <= '0;
         start_h_ff     <= '0;
         prev_h_ff      <= '0;
         prev_stamp_ff  <= '0;
         prev_dist_ff   <= '0;
      end else begin
         target_dist_ff <= target_dist_in;
         target_ang_ff  <= target_ang_in;
         dist_tol_ff    <= dist_tol_in;
         tol_ang_ff     <= tol_ang_in;
         lin_kp_ff      <= lin_kp_in;
         lin_kd_ff      <= lin_kd_in;
         rot_kp_ff      <= rot_kp_in;
         rot_kd_ff      <= rot_kd_in;
         started_ff     <= started_in;
         start_x_ff     <= start_x_in;
         start_y_ff     <= start_y_in;
         start_h_ff     <= start_h_in;
         prev_h_ff      <= prev_h_in;
         prev_stamp_ff  <= prev_stamp_in;
         prev_dist_ff   <= prev_dist_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      h_ff         <= h_in;
      stamp_ff     <= stamp_in;
      ux_ff        <= ux_in;
      uy_ff        <= uy_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      rad_ff       <= rad_in;
      srem_ff      <= srem_in;
      root_ff      <= root_in;
      lin_err_ff   <= lin_err_in;
      lin_diff_ff  <= lin_diff_in;
      ang_err_ff   <= ang_err_in;
      ang_diff_ff  <= ang_diff_in;
      lin_en_ff    <= lin_en_in;
      arr_ff       <= arr_in;
      dt_ff        <= dt_in;
      p_ff         <= p_in;
      num_neg_ff   <= num_neg_in;
      quo_ff       <= quo_in;
      drem_ff      <= drem_in;
      qm_ff        <= qm_in;
      dlo_ff       <= dlo_in;
      dhi_ff       <= dhi_in;
      d_ff         <= d_in;
      speed_res_ff <= speed_res_in;
      turn_res_ff  <= turn_res_in;
      speed_out_ff <= speed_out_in;
      turn_out_ff  <= turn_out_in;
      arr_out_ff   <= arr_out_in;
   end

   assign status.dt_zero = (dt_ff == '0);
   assign speed_cmd      = speed_out_ff;
   assign turn_cmd       = turn_out_ff;
   assign arrived        = arr_out_ff;

endmodule
`default_nettype wire

// ----- design/pose_pd_position_controller_top.sv -----
`default_nettype none
// PD position controller on odometry: each req_ch transaction (x, y, heading,
// timestamp) yields one rsp_ch transaction with a speed command, a turn command
// and an arrival flag. One sample is processed at a time: a bit-per-cycle
// square root for the travelled distance, then for each of the linear and the
// angular loop a restoring divider for the rate term plus multiplies (the
// divider is skipped when the time step is zero). A finished result waits in an
// output register, so the next sample is taken while it is pending. Write the
// csr_ registers only while idle.
module pose_pd_position_controller_top
   import pdpc_pkg::*;
#(
   parameter int POS_FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   pdpc_req_if.sink                   req_ch,
   pdpc_rsp_if.source                 rsp_ch
);

   cmd_type    cmd;
   status_type status;

   pdpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   pdpc_datapath #(
      .POS_FRAC_BITS (POS_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pos_x     (req_ch.pos_x),
      .pos_y     (req_ch.pos_y),
      .heading   (req_ch.heading),
      .stamp_us  (req_ch.stamp_us),
      .cmd       (cmd),
      .status    (status),
      .speed_cmd (rsp_ch.speed_cmd),
      .turn_cmd  (rsp_ch.turn_cmd),
      .arrived   (rsp_ch.arrived)
   );

endmodule
`default_nettype wire
